@@ src/cft_pkg.sv @@
// shared types, constants and codes of the csv field tokenizer
`timescale 1ns / 1ps

package cft_pkg;

    localparam int MAX_COLUMNS = 256;
    // wide enough for the saturated column count plus one
    localparam int COL_W       = $clog2(MAX_COLUMNS + 2);
    localparam int COL_IDX_W   = 9;
    localparam int LEN_W       = 8;
    localparam int LINE_W      = 32;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] TAB_CHAR     = 8'h09;
    localparam logic [7:0] CR_CHAR      = 8'h0D;

    localparam logic [LEN_W-1:0] MAX_FIELD_LEN_RST = 8'd41;
    localparam logic [7:0]       SEPARATOR_RST     = 8'd44;
    localparam logic [7:0]       COMMENT_RST       = 8'd35;
    localparam logic             CHECK_COLUMNS_RST = 1'b1;

    typedef enum logic [1:0] {
        EV_SEPARATOR = 2'd0,
        EV_NEWLINE   = 2'd1,
        EV_END       = 2'd2,
        EV_TOO_LONG  = 2'd3
    } cft_event_t;

    typedef enum logic [1:0] {
        REG_MAX_FIELD_LEN = 2'd0,
        REG_SEPARATOR     = 2'd1,
        REG_COMMENT       = 2'd2,
        REG_CHECK_COLUMNS = 2'd3
    } cft_reg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0] max_field_len;
        logic [7:0]       separator_char;
        logic [7:0]       comment_byte;
        logic             check_columns;
    } cft_cfg_t;

    typedef struct packed {
        cft_event_t           event_code;
        logic [COL_IDX_W-1:0] column_index;
        logic [LEN_W-1:0]     field_len;
        logic [LEN_W-1:0]     trim_start;
        logic [LEN_W-1:0]     trim_len;
        logic [LINE_W-1:0]    line_number;
        logic                 blank_line;
        logic                 column_mismatch;
    } cft_result_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
    endfunction

endpackage

@@ src/cft_cfg_regs.sv @@
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module cft_cfg_regs
    import cft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cft_cfg_t          cfg
);

    cft_cfg_t     cfg_reg;
    cft_cfg_t     cfg_next;
    cft_reg_idx_t reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = cft_reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAX_FIELD_LEN: cfg_next.max_field_len  = pwdata[LEN_W-1:0];
                REG_SEPARATOR:     cfg_next.separator_char = pwdata[7:0];
                REG_COMMENT:       cfg_next.comment_byte   = pwdata[7:0];
                REG_CHECK_COLUMNS: cfg_next.check_columns  = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MAX_FIELD_LEN: prdata = DATA_W'(cfg_reg.max_field_len);
            REG_SEPARATOR:     prdata = DATA_W'(cfg_reg.separator_char);
            REG_COMMENT:       prdata = DATA_W'(cfg_reg.comment_byte);
            REG_CHECK_COLUMNS: prdata = DATA_W'(cfg_reg.check_columns);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_field_len  <= MAX_FIELD_LEN_RST;
            cfg_reg.separator_char <= SEPARATOR_RST;
            cfg_reg.comment_byte   <= COMMENT_RST;
            cfg_reg.check_columns  <= CHECK_COLUMNS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/cft_step.sv @@
// tokenizer state and the per-byte update logic
`timescale 1ns / 1ps

module cft_step
    import cft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    input  cft_cfg_t    cfg,
    output logic        fire,
    output cft_result_t result
);

    logic              at_line_start_reg,  at_line_start_next;
    logic              in_comment_reg,     in_comment_next;
    logic [LEN_W-1:0]  field_count_reg,    field_count_next;
    logic [LEN_W-1:0]  first_text_pos_reg, first_text_pos_next;
    logic [LEN_W-1:0]  last_text_pos_reg,  last_text_pos_next;
    logic              seen_text_reg,      seen_text_next;
    logic [COL_W-1:0]  column_count_reg,   column_count_next;
    logic [COL_W-1:0]  header_columns_reg, header_columns_next;
    logic              header_done_reg,    header_done_next;
    logic [LINE_W-1:0] lines_done_reg,     lines_done_next;
    logic              error_stop_reg,     error_stop_next;

    logic             is_nl;
    logic             is_blank;
    logic             is_over;
    logic             is_mism;
    logic [COL_W-1:0] col_plus_one;

    assign is_nl        = (in_byte == NEWLINE_CHAR);
    assign col_plus_one = column_count_reg + COL_W'(1);
    assign is_blank     = (column_count_reg == '0) && !seen_text_reg;
    assign is_over      = (column_count_reg >= COL_W'(MAX_COLUMNS));
    assign is_mism      = !is_blank && (is_over || (header_done_reg && cfg.check_columns
                          && (col_plus_one != header_columns_reg)));

    always_comb
    begin
        at_line_start_next  = at_line_start_reg;
        in_comment_next     = in_comment_reg;
        field_count_next    = field_count_reg;
        first_text_pos_next = first_text_pos_reg;
        last_text_pos_next  = last_text_pos_reg;
        seen_text_next      = seen_text_reg;
        column_count_next   = column_count_reg;
        header_columns_next = header_columns_reg;
        header_done_next    = header_done_reg;
        lines_done_next     = lines_done_reg;
        error_stop_next     = error_stop_reg;
        fire                = 1'b0;

        result.event_code      = EV_SEPARATOR;
        result.column_index    = COL_IDX_W'(column_count_reg);
        result.field_len       = field_count_reg;
        result.trim_start      = seen_text_reg ? first_text_pos_reg : field_count_reg;
        result.trim_len        = seen_text_reg
                                 ? (last_text_pos_reg - first_text_pos_reg + LEN_W'(1))
                                 : '0;
        result.line_number     = lines_done_reg;
        result.blank_line      = 1'b0;
        result.column_mismatch = 1'b0;

        if (go && !error_stop_reg)
        begin
            if (end_of_input || (!in_comment_reg && is_nl
                && !(at_line_start_reg && in_byte == cfg.comment_byte)))
            begin
                // line end: newline or end of text
                fire                   = 1'b1;
                result.event_code      = end_of_input ? EV_END : EV_NEWLINE;
                result.blank_line      = is_blank;
                result.column_mismatch = is_mism;
                if (!header_done_reg)
                begin
                    header_columns_next = col_plus_one;
                    header_done_next    = 1'b1;
                end
                lines_done_next     = lines_done_reg + LINE_W'(1);
                column_count_next   = '0;
                field_count_next    = '0;
                first_text_pos_next = '0;
                last_text_pos_next  = '0;
                seen_text_next      = 1'b0;
                at_line_start_next  = 1'b1;
                in_comment_next     = 1'b0;
            end
            else if (in_comment_reg)
            begin
                if (is_nl)
                begin
                    in_comment_next    = 1'b0;
                    at_line_start_next = 1'b1;
                end
            end
            else if (at_line_start_reg && in_byte == cfg.comment_byte)
            begin
                in_comment_next = 1'b1;
            end
            else if (in_byte == cfg.separator_char)
            begin
                fire              = 1'b1;
                result.event_code = EV_SEPARATOR;
                if (!is_over)
                begin
                    column_count_next = col_plus_one;
                end
                field_count_next    = '0;
                first_text_pos_next = '0;
                last_text_pos_next  = '0;
                seen_text_next      = 1'b0;
                at_line_start_next  = 1'b0;
            end
            else if (field_count_reg >= cfg.max_field_len)
            begin
                fire              = 1'b1;
                result.event_code = EV_TOO_LONG;
                error_stop_next   = 1'b1;
            end
            else
            begin
                if (!is_space(in_byte))
                begin
                    if (!seen_text_reg)
                    begin
                        first_text_pos_next = field_count_reg;
                    end
                    last_text_pos_next = field_count_reg;
                    seen_text_next     = 1'b1;
                end
                field_count_next   = field_count_reg + LEN_W'(1);
                at_line_start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg  <= 1'b1;
            in_comment_reg     <= 1'b0;
            field_count_reg    <= '0;
            first_text_pos_reg <= '0;
            last_text_pos_reg  <= '0;
            seen_text_reg      <= 1'b0;
            column_count_reg   <= '0;
            header_columns_reg <= '0;
            header_done_reg    <= 1'b0;
            lines_done_reg     <= '0;
            error_stop_reg     <= 1'b0;
        end
        else
        begin
            at_line_start_reg  <= at_line_start_next;
            in_comment_reg     <= in_comment_next;
            field_count_reg    <= field_count_next;
            first_text_pos_reg <= first_text_pos_next;
            last_text_pos_reg  <= last_text_pos_next;
            seen_text_reg      <= seen_text_next;
            column_count_reg   <= column_count_next;
            header_columns_reg <= header_columns_next;
            header_done_reg    <= header_done_next;
            lines_done_reg     <= lines_done_next;
            error_stop_reg     <= error_stop_next;
        end
    end

endmodule

@@ src/cft_out_stage.sv @@
// result register between the update logic and the result channel
`timescale 1ns / 1ps

module cft_out_stage
    import cft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  cft_result_t result_in,
    input  logic        result_ready,
    output logic        result_valid,
    output logic        free,
    output cft_result_t result_out
);

    logic        valid_reg;
    logic        valid_next;
    cft_result_t data_reg;

    assign free         = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result_out   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

@@ src/csv_field_tokenizer_unit.sv @@
// top level of the csv field tokenizer
`timescale 1ns / 1ps

// Splits a byte stream into csv fields, one byte per request, and reports
// each closed field (column, raw length, trimmed start and length, line
// number, blank and column-mismatch flags) as one result request. Lines
// opening with the comment byte are dropped through their newline; the
// first non-comment line sets the expected column count. A field longer
// than max_field_len reports a too-long result and the block then ignores
// everything until reset. Throughput is one byte per clock while the result
// channel does not stall: the byte is registered, the state update and
// result build are combinational, and the result is loaded into an output
// register. A stalled result holds one byte in the input register and
// back-pressures the byte channel.
module csv_field_tokenizer_unit
    import cft_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_input,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [1:0]           event_res,
    output logic [COL_IDX_W-1:0] column_index,
    output logic [LEN_W-1:0]     field_len,
    output logic [LEN_W-1:0]     trim_start,
    output logic [LEN_W-1:0]     trim_len,
    output logic [LINE_W-1:0]    line_number,
    output logic                 blank_line,
    output logic                 column_mismatch
);

    cft_cfg_t    cfg;
    cft_result_t step_res;
    cft_result_t out_res;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [7:0]  byte_reg;
    logic        eoi_reg;
    logic        out_free;
    logic        advance;
    logic        fire;
    logic        take;

    assign advance    = item_valid_reg && out_free;
    assign byte_ready = !item_valid_reg || advance;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_byte;
            eoi_reg  <= end_of_input;
        end
    end

    cft_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cft_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (advance),
        .in_byte      (byte_reg),
        .end_of_input (eoi_reg),
        .cfg          (cfg),
        .fire         (fire),
        .result       (step_res)
    );

    cft_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && fire),
        .result_in    (step_res),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .free         (out_free),
        .result_out   (out_res)
    );

    assign event_res       = out_res.event_code;
    assign column_index    = out_res.column_index;
    assign field_len       = out_res.field_len;
    assign trim_start      = out_res.trim_start;
    assign trim_len        = out_res.trim_len;
    assign line_number     = out_res.line_number;
    assign blank_line      = out_res.blank_line;
    assign column_mismatch = out_res.column_mismatch;

endmodule

@@ sim/testbench.sv @@
// testbench for the csv field tokenizer unit: byte stream in, field reports checked
`timescale 1ns / 1ps

module testbench;
    import cft_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_SHOWN   = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 byte_valid = 1'b0;
    logic                 byte_ready;
    logic [7:0]           in_byte = 8'h00;
    logic                 end_of_input = 1'b0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [1:0]           event_res;
    logic [COL_IDX_W-1:0] column_index;
    logic [LEN_W-1:0]     field_len;
    logic [LEN_W-1:0]     trim_start;
    logic [LEN_W-1:0]     trim_len;
    logic [LINE_W-1:0]    line_number;
    logic                 blank_line;
    logic                 column_mismatch;

    csv_field_tokenizer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .in_byte        (in_byte),
        .end_of_input   (end_of_input),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .event_res      (event_res),
        .column_index   (column_index),
        .field_len      (field_len),
        .trim_start     (trim_start),
        .trim_len       (trim_len),
        .line_number    (line_number),
        .blank_line     (blank_line),
        .column_mismatch(column_mismatch)
    );

    always #4 clk = ~clk;

    // tokenizer state as the block should hold it
    cft_cfg_t    cfg_shadow = '{MAX_FIELD_LEN_RST, SEPARATOR_RST, COMMENT_RST,
                                CHECK_COLUMNS_RST};
    logic        p_line_start = 1'b1;
    logic        p_in_comment = 1'b0;
    logic        p_seen = 1'b0;
    logic        p_header_done = 1'b0;
    logic        p_stopped = 1'b0;
    logic [7:0]  p_len = 8'd0;
    logic [7:0]  p_first = 8'd0;
    logic [7:0]  p_last = 8'd0;
    int unsigned p_cols = 0;
    int unsigned p_header_cols = 0;
    logic [31:0] p_lines = 32'd0;

    cft_result_t field_reports_q[$];

    int bytes_sent = 0;
    int settings_count = 0;
    int reports_checked = 0;
    int mismatch_count = 0;
    int ev_count [4] = '{default: 0};
    int cycle_count = 0;

    // request pacing on both sides
    bit sender_gaps = 1'b1;
    bit ready_random = 1'b1;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    cft_result_t want_report;
    cft_result_t got_report;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(0, 4))
            0: return TAB_CHAR;
            1: return 8'h0B;
            2: return 8'h0C;
            3: return CR_CHAR;
            default: return SPACE_CHAR;
        endcase
    endfunction

    function automatic cft_result_t field_report(cft_event_t ev, logic blank, logic mism);
        cft_result_t r;
        r.event_code      = ev;
        r.column_index    = p_cols[COL_IDX_W-1:0];
        r.field_len       = p_len;
        r.trim_start      = p_seen ? p_first : p_len;
        r.trim_len        = p_seen ? (p_last - p_first + 8'd1) : 8'd0;
        r.line_number     = p_lines;
        r.blank_line      = blank;
        r.column_mismatch = mism;
        return r;
    endfunction

    task automatic queue_report(cft_result_t r);
        field_reports_q.insert(field_reports_q.size(), r);
    endtask

    task automatic clear_open_field();
        p_len   = 8'd0;
        p_first = 8'd0;
        p_last  = 8'd0;
        p_seen  = 1'b0;
    endtask

    task automatic close_line(cft_event_t ev);
        logic blank;
        logic mism;
        blank = (p_cols == 0) && !p_seen;
        mism  = !blank && ((p_cols >= MAX_COLUMNS) ||
                (p_header_done && cfg_shadow.check_columns && (p_cols + 1 != p_header_cols)));
        queue_report(field_report(ev, blank, mism));
        // the first line to end fixes the column count for good
        if (!p_header_done)
        begin
            p_header_cols = p_cols + 1;
            p_header_done = 1'b1;
        end
        p_lines++;
        p_cols = 0;
        clear_open_field();
        p_line_start = 1'b1;
    endtask

    task automatic tokenize_byte(logic [7:0] b, logic eoi);
        if (p_stopped)
            return;
        if (eoi)
        begin
            p_in_comment = 1'b0;
            close_line(EV_END);
        end
        else if (p_in_comment)
        begin
            if (b == NEWLINE_CHAR)
            begin
                p_in_comment = 1'b0;
                p_line_start = 1'b1;
            end
        end
        else if (p_line_start && b == cfg_shadow.comment_byte)
            p_in_comment = 1'b1;
        else if (b == NEWLINE_CHAR)
            close_line(EV_NEWLINE);
        else if (b == cfg_shadow.separator_char)
        begin
            queue_report(field_report(EV_SEPARATOR, 1'b0, 1'b0));
            if (p_cols < MAX_COLUMNS)
                p_cols++;
            clear_open_field();
            p_line_start = 1'b0;
        end
        else if (p_len >= cfg_shadow.max_field_len)
        begin
            queue_report(field_report(EV_TOO_LONG, 1'b0, 1'b0));
            p_stopped = 1'b1;
        end
        else
        begin
            if (!((b == SPACE_CHAR) || (b >= TAB_CHAR && b <= CR_CHAR)))
            begin
                if (!p_seen)
                    p_first = p_len;
                p_last = p_len;
                p_seen = 1'b1;
            end
            p_len++;
            p_line_start = 1'b0;
        end
    endtask

    task automatic send_byte(logic [7:0] b, logic eoi);
        int n;
        byte_valid   <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        tokenize_byte(b, eoi);
        bytes_sent++;
        if (sender_gaps)
        begin
            n = idle_len();
            if (n > 0)
            begin
                byte_valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // random text must never trip the sticky too-long error
    task automatic send_safe(logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (!p_in_comment && !p_stopped && c != NEWLINE_CHAR &&
            c != cfg_shadow.separator_char &&
            !(p_line_start && c == cfg_shadow.comment_byte) &&
            p_len >= cfg_shadow.max_field_len)
            c = NEWLINE_CHAR;
        send_byte(c, 1'b0);
    endtask

    function automatic logic [7:0] keep_in_field(logic [7:0] b);
        logic [7:0] c;
        c = b;
        for (int k = 0; k < 3; k++)
            if (c == NEWLINE_CHAR || c == cfg_shadow.separator_char ||
                (p_line_start && c == cfg_shadow.comment_byte))
                c = 8'h78 + 8'(k);
        return c;
    endfunction

    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (field_reports_q.size() != 0)
            @(posedge clk);
        // data bytes leave no report, give them time to clear the pipe
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cft_reg_idx_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAX_FIELD_LEN: cfg_shadow.max_field_len  = value[LEN_W-1:0];
            REG_SEPARATOR:     cfg_shadow.separator_char = value[7:0];
            REG_COMMENT:       cfg_shadow.comment_byte   = value[7:0];
            REG_CHECK_COLUMNS: cfg_shadow.check_columns  = value[0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(logic [7:0] max_len, logic [7:0] sep, logic [7:0] com,
                                  logic chk);
        wait_idle();
        write_reg(REG_MAX_FIELD_LEN, DATA_W'(max_len));
        write_reg(REG_SEPARATOR, DATA_W'(sep));
        write_reg(REG_COMMENT, DATA_W'(com));
        write_reg(REG_CHECK_COLUMNS, DATA_W'(chk));
        settings_count++;
    endtask

    task automatic random_field();
        int n;
        int r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 70)
            n = $urandom_range(0, 5);
        else if (r < 95)
            n = $urandom_range(0, 20);
        else
            n = $urandom_range(0, cfg_shadow.max_field_len);
        if (n > cfg_shadow.max_field_len)
            n = cfg_shadow.max_field_len;
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                b = ws_byte();
            else if (r < 8)
                b = 8'h61 + 8'($urandom_range(0, 25));
            else
                b = 8'($urandom_range(0, 255));
            send_safe(keep_in_field(b));
        end
    endtask

    // mostly well-formed lines, with blank lines, comments, odd column counts and noise
    task automatic random_text(int n);
        int stop_at;
        int r;
        int ncols;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                repeat ($urandom_range(0, 2)) send_safe(ws_byte());
                send_safe(NEWLINE_CHAR);
            end
            else if (r < 16)
            begin
                send_safe(cfg_shadow.comment_byte);
                repeat ($urandom_range(0, 8)) send_safe(8'($urandom_range(0, 255)));
                send_safe(NEWLINE_CHAR);
            end
            else if (r < 24)
            begin
                repeat ($urandom_range(1, 6)) send_safe(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else
            begin
                ncols = (p_header_cols == 0) ? 3 : int'(p_header_cols);
                if (r < 36)
                    ncols = ncols + $urandom_range(0, 2) - 1;
                if (ncols < 1)
                    ncols = 1;
                for (int k = 0; k < ncols; k++)
                begin
                    if (k > 0)
                        send_safe(cfg_shadow.separator_char);
                    random_field();
                end
                r = $urandom_range(0, 9);
                if (r == 0)
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                else
                begin
                    if (r == 1)
                        send_safe(CR_CHAR);
                    send_safe(NEWLINE_CHAR);
                end
            end
        end
    endtask

    task automatic test_header();
        send_text("#h,x\n");
        // a blank first line counts as a one-column header
        if ($urandom_range(0, 2) == 0)
            send_text(" \t\n");
        else
            send_text("id, name ,val\n");
    endtask

    task automatic test_special_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text(",");
        send_byte(TAB_CHAR, 1'b0);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(CR_CHAR, 1'b0);
        send_byte(SPACE_CHAR, 1'b0);
        send_text(",");
        send_text(" #x \n");
        send_text("\n");
        send_text(",\n");
        // end of input closes the open field, the byte itself is ignored
        send_text("ab");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_text("#c");
        send_byte(8'h5A, 1'b1);
        send_text("x");
        send_byte(CR_CHAR, 1'b0);
        send_text("\n");
    endtask

    task automatic test_register_cases();
        // comment byte wins over separator at line start
        apply_settings(8'd41, ";", ";", 1'b1);
        send_text(";a;b\n");
        send_text("a;b\n");
        // at line start the comment byte wins even over newline, elsewhere newline wins
        apply_settings(8'd41, NEWLINE_CHAR, NEWLINE_CHAR, 1'b1);
        send_text("\nz,\n");
        send_text("k\n");
        apply_settings(8'd1, 8'hFF, 8'h00, 1'b0);
        send_text("a");
        send_byte(8'hFF, 1'b0);
        send_text("b\n");
        send_byte(8'h00, 1'b0);
        send_text("xx\n");
        send_text("q\n");
    endtask

    task automatic test_column_bound();
        // past the column bound the line is flagged even with checking off
        apply_settings(8'd41, ",", "#", 1'b0);
        repeat (258) send_byte(",", 1'b0);
        send_text("z\n");
    endtask

    task automatic test_long_field();
        apply_settings(8'd254, ",", "#", 1'b1);
        for (int i = 0; i < 254; i++)
            send_byte((i < 3) ? SPACE_CHAR : (i >= 251) ? TAB_CHAR : 8'h71, 1'b0);
        send_text(",\n");
    endtask

    task automatic test_random_phases();
        apply_settings(8'd41, ",", "#", 1'b1);
        random_text(160);
        apply_settings(8'd1, 8'hFF, 8'h00, 1'b0);
        random_text(160);
        apply_settings(8'd254, TAB_CHAR, ";", 1'b1);
        sender_gaps = 1'b0;
        random_text(160);
        sender_gaps = 1'b1;
        apply_settings(8'($urandom_range(2, 253)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        ready_random = 1'b0;
        random_text(160);
        ready_random = 1'b1;
        apply_settings(8'd254, 8'h00, 8'hFF, 1'b1);
        random_text(160);
        apply_settings(8'd20, ",", "#", 1'b1);
        random_text(160);
    endtask

    task automatic test_backpressure();
        apply_settings(8'd41, ",", "#", 1'b1);
        sender_gaps = 1'b0;
        hold_req++;
        repeat (80) send_byte(",", 1'b0);
        send_text("\n");
        wait_idle();
        sender_gaps = 1'b1;
    endtask

    task automatic test_too_long();
        // error is sticky until reset, so this runs last
        apply_settings(8'd3, ",", "#", 1'b1);
        send_text("\nabcd");
        send_text("x,\n");
        send_byte(8'hC3, 1'b1);
    endtask

    // receiver pacing, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (!ready_random)
            result_ready <= 1'b1;
        else
        begin
            stall_left = idle_len();
            if (stall_left == 0)
                result_ready <= 1'b1;
            else
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            got_report.event_code      = cft_event_t'(event_res);
            got_report.column_index    = column_index;
            got_report.field_len       = field_len;
            got_report.trim_start      = trim_start;
            got_report.trim_len        = trim_len;
            got_report.line_number     = line_number;
            got_report.blank_line      = blank_line;
            got_report.column_mismatch = column_mismatch;
            ev_count[event_res]++;
            if (field_reports_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected report: ev=%0d col=%0d len=%0d", event_res,
                             column_index, field_len);
            end
            else
            begin
                want_report = field_reports_q.pop_front();
                if (got_report.event_code != want_report.event_code ||
                    got_report.column_index != want_report.column_index ||
                    got_report.field_len != want_report.field_len ||
                    got_report.trim_start != want_report.trim_start ||
                    got_report.trim_len != want_report.trim_len ||
                    got_report.line_number != want_report.line_number ||
                    got_report.blank_line != want_report.blank_line ||
                    got_report.column_mismatch != want_report.column_mismatch)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                    begin
                        $write("report %0d expected ev=%0d col=%0d len=%0d",
                               reports_checked, want_report.event_code,
                               want_report.column_index, want_report.field_len);
                        $display(" ts=%0d tl=%0d line=%0d blank=%0b mism=%0b",
                                 want_report.trim_start, want_report.trim_len,
                                 want_report.line_number, want_report.blank_line,
                                 want_report.column_mismatch);
                        $write("report %0d actual   ev=%0d col=%0d len=%0d",
                               reports_checked, got_report.event_code,
                               got_report.column_index, got_report.field_len);
                        $display(" ts=%0d tl=%0d line=%0d blank=%0b mism=%0b",
                                 got_report.trim_start, got_report.trim_len,
                                 got_report.line_number, got_report.blank_line,
                                 got_report.column_mismatch);
                    end
                end
            end
            reports_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding", CYCLE_LIMIT,
                     field_reports_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header();
        test_special_bytes();
        test_register_cases();
        test_column_bound();
        test_long_field();
        test_random_phases();
        test_backpressure();
        test_too_long();
        wait_idle();
        $display("sent %0d bytes under %0d register settings, checked %0d field reports",
                 bytes_sent, settings_count, reports_checked);
        $display("reports by event: separator %0d, newline %0d, end of input %0d, too long %0d",
                 ev_count[EV_SEPARATOR], ev_count[EV_NEWLINE], ev_count[EV_END],
                 ev_count[EV_TOO_LONG]);
        if (mismatch_count == 0 && field_reports_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
src/cft_pkg.sv
src/cft_cfg_regs.sv
src/cft_step.sv
src/cft_out_stage.sv
src/csv_field_tokenizer_unit.sv
sim/testbench.sv
